### rtl/core/qdds_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the quad DDS waveform generator.
// No dependencies; every other file in rtl/core uses it by scoped names.
package qdds_pkg;

  // Parameter defaults
  localparam int TABLE_DEPTH_DEF  = 256;
  localparam int NUM_CHANNELS_DEF = 4;

  // Fixed field widths
  localparam int OP_W    = 2;
  localparam int TSEL_W  = 2;
  localparam int IDX_W   = 8;
  localparam int SMP_W   = 8;
  localparam int CH_W    = 2;
  localparam int GAIN_W  = 12;
  localparam int PHASE_W = 32;
  localparam int WORD_W  = 16;
  localparam int IDX_RANGE = 256;
  localparam int MAX_CH  = 4;

  // Input opcodes
  localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
  localparam logic [OP_W-1:0] OP_TABLE_WR = 2'd1;
  localparam logic [OP_W-1:0] OP_GAIN_WR  = 2'd2;

  // Table selects
  localparam logic [TSEL_W-1:0] TSEL_TRI  = 2'd0;
  localparam logic [TSEL_W-1:0] TSEL_SINE = 2'd1;
  localparam logic [TSEL_W-1:0] TSEL_ARB  = 2'd2;

  // Wave modes
  localparam logic [2:0] MODE_SQUARE = 3'd0;
  localparam logic [2:0] MODE_TRI    = 3'd1;
  localparam logic [2:0] MODE_SINE   = 3'd2;
  localparam logic [2:0] MODE_SAW    = 3'd3;
  localparam logic [2:0] MODE_ARB    = 3'd4;
  localparam logic [2:0] MODE_PULSE  = 3'd5;

  // Config register indexes
  localparam logic [2:0] REG_WAVE_MODE   = 3'd0;
  localparam logic [2:0] REG_PULSE_WIDTH = 3'd1;
  localparam logic [2:0] REG_STEP_CH0    = 3'd2;
  localparam logic [2:0] REG_STEP_CH1    = 3'd3;
  localparam logic [2:0] REG_STEP_CH2    = 3'd4;
  localparam logic [2:0] REG_STEP_CH3    = 3'd5;

  // Sample and DAC constants
  localparam logic [SMP_W-1:0]  SQUARE_HIGH  = 8'd100;
  localparam logic [SMP_W-1:0]  ALT_HIGH     = 8'd128;
  localparam logic [IDX_W-1:0]  SQUARE_EDGE  = 8'd128;
  localparam logic [7:0]        PULSE_RESET  = 8'd128;
  localparam logic [WORD_W-1:0] DAC_CMD_A    = 16'h3000;
  localparam logic [WORD_W-1:0] DAC_CMD_B    = 16'hB000;
  localparam int                PHASE_SHIFT  = 24;
  // floor(x/3) == (x*171) >> 9 for any 8-bit x
  localparam logic [8:0]        DIV3_MUL     = 9'd171;
  localparam int                DIV3_SHIFT   = 9;

  // Output buffer
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = 3;
  localparam int OUT_CW    = 4;

  typedef struct packed {
    logic [WORD_W-1:0] spi_word;
    logic              dac_select;
    logic              last;
  } out_word_t;

  // One pipeline slot leaving the sequencer
  typedef struct packed {
    logic               vld;
    logic [OP_W-1:0]    kind;
    logic [CH_W-1:0]    ch;
    logic               last;
    logic [TSEL_W-1:0]  tsel;
    logic [IDX_W-1:0]   entry_index;
    logic [SMP_W-1:0]   entry_value;
  } slot_t;

endpackage

### rtl/core/qdds_state_mem.sv
`timescale 1ns / 1ps
// Small per-channel state memory: one write and one registered read port,
// zero after reset via per-entry valid bits, same-cycle write forwarding. Uses qdds_pkg.
module qdds_state_mem #(
  parameter int WIDTH = qdds_pkg::PHASE_W,
  parameter int DEPTH = qdds_pkg::NUM_CHANNELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [qdds_pkg::CH_W-1:0] rd_addr,
  output logic [WIDTH-1:0]          rd_data,
  input  logic                      wr_en,
  input  logic [qdds_pkg::CH_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]          wr_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] mem_q;
  logic             vld_q;
  logic             fwd;
  logic [WIDTH-1:0] fwd_data;
  logic [AW-1:0]    ra;
  logic [AW-1:0]    wa;

  assign ra = rd_addr[AW-1:0];
  assign wa = wr_addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wa] <= wr_data;
    end
    mem_q    <= mem[ra];
    fwd_data <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
      fwd   <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wa] <= 1'b1;
      end
      vld_q <= vld[ra];
      // read and write of one entry in the same cycle: take the new value
      fwd   <= wr_en && (wa == ra);
    end
  end

  assign rd_data = fwd ? fwd_data : (vld_q ? mem_q : '0);

endmodule

### rtl/core/qdds_wave_ram.sv
`timescale 1ns / 1ps
// Triangle, sine and arbitrary sample tables: one write port, one registered
// read port; addresses wrap modulo TABLE_DEPTH. Uses qdds_pkg.
module qdds_wave_ram #(
  parameter int TABLE_DEPTH = qdds_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [qdds_pkg::TSEL_W-1:0] wr_sel,
  input  logic [qdds_pkg::IDX_W-1:0]  wr_index,
  input  logic [qdds_pkg::SMP_W-1:0]  wr_value,
  input  logic [qdds_pkg::TSEL_W-1:0] rd_sel,
  input  logic [qdds_pkg::IDX_W-1:0]  rd_index,
  output logic [qdds_pkg::SMP_W-1:0]  rd_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [AW-1:0]                addr_rom [qdds_pkg::IDX_RANGE];
  logic [qdds_pkg::SMP_W-1:0]   tri_mem  [TABLE_DEPTH];
  logic [qdds_pkg::SMP_W-1:0]   sine_mem [TABLE_DEPTH];
  logic [qdds_pkg::SMP_W-1:0]   arb_mem  [TABLE_DEPTH];
  logic [qdds_pkg::SMP_W-1:0]   tri_q, sine_q, arb_q;
  logic [qdds_pkg::TSEL_W-1:0]  sel_q;
  logic [AW-1:0]                wa, ra;

  // index -> wrapped address, built at elaboration
  for (genvar i = 0; i < qdds_pkg::IDX_RANGE; i++) begin : g_addr
    assign addr_rom[i] = AW'(i % TABLE_DEPTH);
  end

  assign wa = addr_rom[wr_index];
  assign ra = addr_rom[rd_index];

  always_ff @(posedge clk) begin
    if (wr_en && wr_sel == qdds_pkg::TSEL_TRI) begin
      tri_mem[wa] <= wr_value;
    end
    if (wr_en && wr_sel == qdds_pkg::TSEL_SINE) begin
      sine_mem[wa] <= wr_value;
    end
    if (wr_en && wr_sel == qdds_pkg::TSEL_ARB) begin
      arb_mem[wa] <= wr_value;
    end
    tri_q  <= tri_mem[ra];
    sine_q <= sine_mem[ra];
    arb_q  <= arb_mem[ra];
    sel_q  <= rd_sel;
  end

  always_comb begin
    priority case (sel_q)
      qdds_pkg::TSEL_TRI:  rd_data = tri_q;
      qdds_pkg::TSEL_SINE: rd_data = sine_q;
      default:             rd_data = arb_q;
    endcase
  end

endmodule

### rtl/core/qdds_out_fifo.sv
`timescale 1ns / 1ps
// Output word buffer between the sample pipeline and the stream master port.
// Uses qdds_pkg for the word type and depth.
module qdds_out_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  qdds_pkg::out_word_t        push_data,
  input  logic                       pop,
  output qdds_pkg::out_word_t        head,
  output logic                       not_empty,
  output logic [qdds_pkg::OUT_CW-1:0] count
);

  qdds_pkg::out_word_t          mem [qdds_pkg::OUT_DEPTH];
  logic [qdds_pkg::OUT_AW-1:0]  wr_ptr;
  logic [qdds_pkg::OUT_AW-1:0]  rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);

endmodule

### rtl/core/quad_dds_waveform_generator.sv
`timescale 1ns / 1ps
// Top level of the quad DDS waveform generator; instantiates qdds_state_mem,
// qdds_wave_ram and qdds_out_fifo, and uses qdds_pkg.
//
// Four-channel phase-accumulator NCO producing DAC command words. A tick
// transaction (op 0) steps every channel's 32-bit accumulator and emits one
// 16-bit word per channel in channel order, tlast on the final one; op 1
// loads a triangle/sine/arbitrary table entry, op 2 sets a channel gain;
// neither emits anything. A tick occupies the sequencer for one slot per
// channel and a write for a single slot, so the block sustains one output
// word per clock while the output buffer has room; the next transaction is
// taken in the cycle the previous one issues its last slot. That rate is set
// by the single read port of the phase memory, read once per channel.
// Phase and gain live in small memories that read as zero after reset; the
// wave tables have no reset and must be loaded before a mode uses them.
// Configuration writes must only happen while the block is idle.
module quad_dds_waveform_generator #(
  parameter int TABLE_DEPTH  = qdds_pkg::TABLE_DEPTH_DEF,
  parameter int NUM_CHANNELS = qdds_pkg::NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // table_sel[1:0], entry_index[9:2], entry_value[17:10], channel[19:18],
  // gain_value[31:20]
  input  logic [31:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser,
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // spi_word[15:0]
  output logic [15:0] m_axis_tdata,
  // dac_select[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int CHAN_USED = (NUM_CHANNELS < qdds_pkg::MAX_CH) ? NUM_CHANNELS
                                                              : qdds_pkg::MAX_CH;
  localparam logic [qdds_pkg::CH_W-1:0] LAST_CH = qdds_pkg::CH_W'(CHAN_USED - 1);
  localparam logic [qdds_pkg::CH_W:0]   CH_LIMIT = (qdds_pkg::CH_W + 1)'(CHAN_USED);

  // ---------------- input field unpack ----------------
  logic [qdds_pkg::OP_W-1:0]   in_op;
  logic [qdds_pkg::TSEL_W-1:0] in_tsel;
  logic [qdds_pkg::IDX_W-1:0]  in_index;
  logic [qdds_pkg::SMP_W-1:0]  in_value;
  logic [qdds_pkg::CH_W-1:0]   in_channel;
  logic [qdds_pkg::GAIN_W-1:0] in_gain;

  assign in_op      = s_axis_tuser;
  assign in_tsel    = s_axis_tdata[1:0];
  assign in_index   = s_axis_tdata[9:2];
  assign in_value   = s_axis_tdata[17:10];
  assign in_channel = s_axis_tdata[19:18];
  assign in_gain    = s_axis_tdata[31:20];

  // ---------------- configuration registers ----------------
  logic [2:0]                   wave_mode;
  logic [7:0]                   pulse_width;
  logic [qdds_pkg::PHASE_W-1:0] step_ch [qdds_pkg::MAX_CH];

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_mode   <= qdds_pkg::MODE_SQUARE;
      pulse_width <= qdds_pkg::PULSE_RESET;
      for (int i = 0; i < qdds_pkg::MAX_CH; i++) begin
        step_ch[i] <= '0;
      end
    end else if (cfg_we) begin
      priority case (cfg_index)
        qdds_pkg::REG_WAVE_MODE:   wave_mode   <= cfg_wdata[2:0];
        qdds_pkg::REG_PULSE_WIDTH: pulse_width <= cfg_wdata[7:0];
        qdds_pkg::REG_STEP_CH0:    step_ch[0]  <= cfg_wdata;
        qdds_pkg::REG_STEP_CH1:    step_ch[1]  <= cfg_wdata;
        qdds_pkg::REG_STEP_CH2:    step_ch[2]  <= cfg_wdata;
        qdds_pkg::REG_STEP_CH3:    step_ch[3]  <= cfg_wdata;
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // ---------------- sequencer ----------------
  // Holds the current transaction and walks its channels one per cycle while the output buffer has room.
  logic                         cur_vld;
  logic [qdds_pkg::OP_W-1:0]    cur_op;
  logic [qdds_pkg::TSEL_W-1:0]  cur_tsel;
  logic [qdds_pkg::IDX_W-1:0]   cur_index;
  logic [qdds_pkg::SMP_W-1:0]   cur_value;
  logic [qdds_pkg::CH_W-1:0]    cur_channel;
  logic [qdds_pkg::GAIN_W-1:0]  cur_gain;
  logic [qdds_pkg::CH_W-1:0]    cur_ch;

  logic cur_is_tick;
  logic room;
  logic issue;
  logic cur_done;
  logic in_accept;
  logic in_useful;

  qdds_pkg::slot_t s0, s1;

  // pipeline stages 2 and 3 (tick slots only)
  logic                         s2_vld, s3_vld;
  logic [qdds_pkg::CH_W-1:0]    s2_ch, s3_ch;
  logic                         s2_last, s3_last;
  logic                         s2_use_ram;
  logic [qdds_pkg::SMP_W-1:0]   s2_calc;
  logic [qdds_pkg::GAIN_W-1:0]  s2_gain;
  logic [qdds_pkg::GAIN_W-1:0]  s3_prod;

  logic [qdds_pkg::OUT_CW-1:0]  fifo_count;
  logic [qdds_pkg::OUT_CW:0]    pending;

  // Words already promised to the buffer: stored plus in flight.
  assign pending = {1'b0, fifo_count}
                 + (qdds_pkg::OUT_CW + 1)'(s1.vld && s1.kind == qdds_pkg::OP_TICK)
                 + (qdds_pkg::OUT_CW + 1)'(s2_vld)
                 + (qdds_pkg::OUT_CW + 1)'(s3_vld);
  assign room = (pending < (qdds_pkg::OUT_CW + 1)'(qdds_pkg::OUT_DEPTH));

  assign cur_is_tick   = (cur_op == qdds_pkg::OP_TICK);
  assign issue         = cur_vld && (!cur_is_tick || room);
  assign cur_done      = issue && (!cur_is_tick || cur_ch == LAST_CH);
  assign s_axis_tready = !cur_vld || cur_done;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Items with no effect (unused op, unused table, absent channel) are dropped here.
  always_comb begin
    unique case (in_op)
      qdds_pkg::OP_TICK:     in_useful = 1'b1;
      qdds_pkg::OP_TABLE_WR: in_useful = (in_tsel != 2'd3);
      qdds_pkg::OP_GAIN_WR:  in_useful = ({1'b0, in_channel} < CH_LIMIT);
      default:               in_useful = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_vld <= 1'b0;
      cur_ch  <= '0;
    end else begin
      priority if (in_accept) begin
        cur_vld <= in_useful;
        cur_ch  <= '0;
      end else if (cur_done) begin
        cur_vld <= 1'b0;
      end else if (issue) begin
        cur_ch  <= cur_ch + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_op      <= in_op;
      cur_tsel    <= in_tsel;
      cur_index   <= in_index;
      cur_value   <= in_value;
      cur_channel <= in_channel;
      cur_gain    <= in_gain;
    end
  end

  always_comb begin
    s0.vld         = issue;
    s0.kind        = cur_op;
    s0.ch          = cur_ch;
    s0.last        = (cur_ch == LAST_CH);
    s0.tsel        = cur_tsel;
    s0.entry_index = cur_index;
    s0.entry_value = cur_value;
  end

  // ---------------- stage 0: phase and gain reads, gain writes ----------------
  logic [qdds_pkg::PHASE_W-1:0] phase_rd;
  logic [qdds_pkg::GAIN_W-1:0]  gain_rd;
  logic [qdds_pkg::PHASE_W-1:0] phase_new;
  logic                         s1_tick;

  assign s1_tick   = s1.vld && s1.kind == qdds_pkg::OP_TICK;
  assign phase_new = phase_rd + step_ch[s1.ch];

  qdds_state_mem #(
    .WIDTH (qdds_pkg::PHASE_W),
    .DEPTH (CHAN_USED)
  ) u_phase_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (s0.ch),
    .rd_data (phase_rd),
    .wr_en   (s1_tick),
    .wr_addr (s1.ch),
    .wr_data (phase_new)
  );

  qdds_state_mem #(
    .WIDTH (qdds_pkg::GAIN_W),
    .DEPTH (CHAN_USED)
  ) u_gain_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (s0.ch),
    .rd_data (gain_rd),
    .wr_en   (issue && cur_op == qdds_pkg::OP_GAIN_WR),
    .wr_addr (cur_channel),
    .wr_data (cur_gain)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.vld <= 1'b0;
    end else begin
      s1.vld <= s0.vld;
    end
  end

  always_ff @(posedge clk) begin
    s1.kind        <= s0.kind;
    s1.ch          <= s0.ch;
    s1.last        <= s0.last;
    s1.tsel        <= s0.tsel;
    s1.entry_index <= s0.entry_index;
    s1.entry_value <= s0.entry_value;
  end

  // ---------------- stage 1: accumulate, table access, computed shapes ----------------
  logic [qdds_pkg::IDX_W-1:0]  wave_idx;
  logic [16:0]                 saw_prod;
  logic [qdds_pkg::SMP_W-1:0]  calc;
  logic                        use_ram;
  logic [qdds_pkg::TSEL_W-1:0] rd_sel;
  logic [qdds_pkg::SMP_W-1:0]  ram_data;

  assign wave_idx = phase_new[qdds_pkg::PHASE_SHIFT +: qdds_pkg::IDX_W];
  assign saw_prod = {9'd0, wave_idx} * {8'd0, qdds_pkg::DIV3_MUL};

  always_comb begin
    calc    = '0;
    use_ram = 1'b0;
    unique case (wave_mode)
      qdds_pkg::MODE_SQUARE:
        calc = (wave_idx > qdds_pkg::SQUARE_EDGE) ? qdds_pkg::SQUARE_HIGH : '0;
      qdds_pkg::MODE_TRI, qdds_pkg::MODE_SINE, qdds_pkg::MODE_ARB:
        use_ram = 1'b1;
      qdds_pkg::MODE_SAW:
        calc = saw_prod[qdds_pkg::DIV3_SHIFT +: qdds_pkg::SMP_W];
      qdds_pkg::MODE_PULSE:
        calc = (wave_idx >= pulse_width) ? qdds_pkg::SQUARE_HIGH : '0;
      default:
        calc = (wave_idx > qdds_pkg::SQUARE_EDGE) ? qdds_pkg::ALT_HIGH : '0;
    endcase
  end

  always_comb begin
    priority case (wave_mode)
      qdds_pkg::MODE_TRI:  rd_sel = qdds_pkg::TSEL_TRI;
      qdds_pkg::MODE_SINE: rd_sel = qdds_pkg::TSEL_SINE;
      default:             rd_sel = qdds_pkg::TSEL_ARB;
    endcase
  end

  // Table writes and reads share stage 1, so they stay in item order.
  qdds_wave_ram #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_wave_ram (
    .clk      (clk),
    .wr_en    (s1.vld && s1.kind == qdds_pkg::OP_TABLE_WR),
    .wr_sel   (s1.tsel),
    .wr_index (s1.entry_index),
    .wr_value (s1.entry_value),
    .rd_sel   (rd_sel),
    .rd_index (wave_idx),
    .rd_data  (ram_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else begin
      s2_vld <= s1_tick;
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_ch      <= s1.ch;
    s2_last    <= s1.last;
    s2_calc    <= calc;
    s2_use_ram <= use_ram;
    s2_gain    <= gain_rd;
  end

  // ---------------- stage 2: gain multiply ----------------
  logic [qdds_pkg::SMP_W-1:0]                 sample;
  logic [qdds_pkg::SMP_W+qdds_pkg::GAIN_W-1:0] scaled;

  assign sample = s2_use_ram ? ram_data : s2_calc;
  assign scaled = {{qdds_pkg::GAIN_W{1'b0}}, sample}
                * {{qdds_pkg::SMP_W{1'b0}}, s2_gain};

  always_ff @(posedge clk) begin
    s3_ch   <= s2_ch;
    s3_last <= s2_last;
    s3_prod <= scaled[qdds_pkg::GAIN_W-1:0];
  end

  // ---------------- stage 3: DAC word and output buffer ----------------
  qdds_pkg::out_word_t push_word;
  qdds_pkg::out_word_t head;
  logic                pop;

  always_comb begin
    push_word.spi_word   = (s3_ch[0] ? qdds_pkg::DAC_CMD_B : qdds_pkg::DAC_CMD_A)
                         | {4'd0, s3_prod};
    push_word.dac_select = s3_ch[1];
    push_word.last       = s3_last;
  end

  assign pop = m_axis_tvalid && m_axis_tready;

  qdds_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s3_vld),
    .push_data (push_word),
    .pop       (pop),
    .head      (head),
    .not_empty (m_axis_tvalid),
    .count     (fifo_count)
  );

  assign m_axis_tdata = head.spi_word;
  assign m_axis_tuser = head.dac_select;
  assign m_axis_tlast = head.last;

endmodule
